@@ hw/rtl/cspmv_pkg.sv @@
// Shared types and constants for the CSR sparse matrix-vector multiply block.
// Used by cspmv_vec_store, cspmv_mac and csr_sparse_matvec_top.
`default_nettype none
package cspmv_pkg;

	localparam int VEC_LEN = 1024;
	localparam int VEC_AW  = $clog2(VEC_LEN);
	localparam int COL_W   = 10;
	localparam int DATA_W  = 32;
	localparam int ROW_W   = 16;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_NZ    = 2'd1,
		OP_EMPTY = 2'd2
	} op_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] op;
		logic       last;
		logic       in_range;
	} stage_ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/cspmv_vec_store.sv @@
// Dense vector store: one write port, one registered read port.
// Depends on cspmv_pkg.
`default_nettype none
module cspmv_vec_store (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [cspmv_pkg::VEC_AW-1:0]  wr_addr,
	input  wire logic [cspmv_pkg::DATA_W-1:0]  wr_data,
	input  wire logic                          rd_en,
	input  wire logic [cspmv_pkg::VEC_AW-1:0]  rd_addr,
	output logic      [cspmv_pkg::DATA_W-1:0]  rd_data
);

	logic [cspmv_pkg::DATA_W-1:0] mem [cspmv_pkg::VEC_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/cspmv_mac.sv @@
// Multiply stage, row accumulator, row counter and result register.
// Depends on cspmv_pkg.
`default_nettype none
module cspmv_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire cspmv_pkg::stage_ctrl_t              ctrl_s1,
	input  wire logic [cspmv_pkg::DATA_W-1:0]        value_s1,
	input  wire logic [cspmv_pkg::DATA_W-1:0]        vec_s1,
	output logic                                     result_valid,
	output logic signed [cspmv_pkg::DATA_W-1:0]      row_sum,
	output logic      [cspmv_pkg::ROW_W-1:0]         row_index
);

	cspmv_pkg::stage_ctrl_t       ctrl_s2;
	logic [cspmv_pkg::DATA_W-1:0] prod_s2;
	logic [cspmv_pkg::DATA_W-1:0] acc_q;
	logic [cspmv_pkg::ROW_W-1:0]  cnt_q;

	logic [cspmv_pkg::DATA_W-1:0] vec_m;
	logic [cspmv_pkg::DATA_W-1:0] sum;
	logic                         emit;
	logic [cspmv_pkg::DATA_W-1:0] emit_sum;

	assign vec_m = ctrl_s1.in_range ? vec_s1 : '0;
	assign sum   = acc_q + prod_s2;

	always_comb begin
		emit     = 1'b0;
		emit_sum = '0;
		if (ctrl_s2.valid) begin
			case (ctrl_s2.op)
				cspmv_pkg::OP_NZ: begin
					emit     = ctrl_s2.last;
					emit_sum = sum;
				end
				cspmv_pkg::OP_EMPTY: begin
					emit = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= value_s1 * vec_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (adv && ctrl_s2.valid) begin
			case (ctrl_s2.op)
				cspmv_pkg::OP_LOAD: begin
					acc_q <= '0;
					cnt_q <= '0;
				end
				cspmv_pkg::OP_NZ: begin
					if (ctrl_s2.last) begin
						acc_q <= '0;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						acc_q <= sum;
					end
				end
				cspmv_pkg::OP_EMPTY: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register; holds while downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			row_sum   <= $signed(emit_sum);
			row_index <= cnt_q;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/csr_sparse_matvec_top.sv @@
// CSR sparse matrix times dense vector: y = A*x, streamed row by row.
// Pipeline: the store read and s1 are registered at the input transfer, the multiply
// goes into s2, and the accumulate into the result register that drives result_valid.
// Throughput: one item per cycle; the whole pipeline holds while result_valid is
// high and result_ready is low, set by the single result register.
// Reset clears pipeline valids, row accumulator and row counter; the vector store
// is not cleared. Depends on cspmv_pkg, cspmv_vec_store, cspmv_mac.
`default_nettype none
module csr_sparse_matvec_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [cspmv_pkg::COL_W-1:0]       column,
	input  wire logic signed [cspmv_pkg::DATA_W-1:0] value,
	input  wire logic                              last_in_row,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output logic signed [cspmv_pkg::DATA_W-1:0]    row_sum,
	output logic      [cspmv_pkg::ROW_W-1:0]       row_index
);

	logic                              adv;
	logic                              accept;
	logic                              in_range;
	logic [cspmv_pkg::VEC_AW-1:0]      addr;
	logic                              wr_en;
	logic [cspmv_pkg::DATA_W-1:0]      vec_s1;
	logic [cspmv_pkg::DATA_W-1:0]      value_s1;
	cspmv_pkg::stage_ctrl_t            ctrl_s1;

	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;
	assign accept     = item_valid && adv;
	assign in_range   = 32'(column) < 32'(cspmv_pkg::VEC_LEN);
	assign addr       = cspmv_pkg::VEC_AW'(column);
	assign wr_en      = accept && (op == cspmv_pkg::OP_LOAD) && in_range;

	cspmv_vec_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data ($unsigned(value)),
		.rd_en   (adv),
		.rd_addr (addr),
		.rd_data (vec_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid    <= item_valid;
			ctrl_s1.op       <= op;
			ctrl_s1.last     <= last_in_row;
			ctrl_s1.in_range <= in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= $unsigned(value);
		end
	end

	cspmv_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.ctrl_s1      (ctrl_s1),
		.value_s1     (value_s1),
		.vec_s1       (vec_s1),
		.result_valid (result_valid),
		.row_sum      (row_sum),
		.row_index    (row_index)
	);

endmodule
`default_nettype wire
